[rtl/pslfa_pkg.sv]
`timescale 1ns / 1ps

package pslfa_pkg;

	// Segment geometry defaults
	localparam int DEF_SEG_BYTES    = 65536;
	localparam int DEF_PAGE_BYTES   = 4096;
	localparam int DEF_HEADER_BYTES = 64;

	// Field widths
	localparam int OFF_W  = 16;
	localparam int CNT_W  = 15;
	localparam int CMD_W  = 2;
	localparam int STS_W  = 2;
	localparam int LOG2_W = 4;

	// Link store geometry: one 16-bit link per 4-byte word
	localparam int STORE_DEPTH = 16384;
	localparam int STORE_AW    = 14;

	localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(16384);

	// Slot size limits and reset value
	localparam logic [LOG2_W-1:0] LOG2_MIN = LOG2_W'(2);
	localparam logic [LOG2_W-1:0] LOG2_MAX = LOG2_W'(11);
	localparam logic [LOG2_W-1:0] LOG2_RST = LOG2_W'(4);

	// Commands
	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REINIT = 2'd2;

	// Result status codes
	localparam logic [STS_W-1:0] STS_OK      = 2'd0;
	localparam logic [STS_W-1:0] STS_NOFREE  = 2'd1;
	localparam logic [STS_W-1:0] STS_RANGE   = 2'd2;
	localparam logic [STS_W-1:0] STS_ALIGN   = 2'd3;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_SLOT_SIZE_LOG2 = 1'b0;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [OFF_W-1:0] slot_offset;
	} req_t;

	typedef struct packed {
		logic [OFF_W-1:0] alloc_offset;
		logic [STS_W-1:0] status;
		logic [CNT_W-1:0] free_slots;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_START,
		ST_CLEAR,
		ST_WALK,
		ST_IDLE,
		ST_FINISH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic rd_en;
		logic init_start;
		logic clear_step;
		logic walk_step;
		logic finish;
	} ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		logic walk_done;
		logic out_free;
	} sts_t;

endpackage

[rtl/pslfa_ctrl.sv]
`timescale 1ns / 1ps

module pslfa_ctrl import pslfa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [CMD_W-1:0] req_command,
	output logic             req_stall,
	input  sts_t             sts,
	output ctl_t             ctl
);

	state_t state_q, state_d;
	logic   pend_q;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.accept && req_command == CMD_REINIT) begin
				pend_q <= 1'b1;
			end else if (ctl.finish) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_START: state_d = ST_CLEAR;
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (sts.walk_done) state_d = pend_q ? ST_FINISH : ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_d = (req_command == CMD_REINIT) ? ST_START : ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_START;
		endcase
	end

	// Drive datapath commands
	always_comb begin
		req_stall      = (state_q != ST_IDLE);
		ctl.accept     = (state_q == ST_IDLE) && req_valid;
		ctl.rd_en      = (state_q == ST_IDLE);
		ctl.init_start = (state_q == ST_START);
		ctl.clear_step = (state_q == ST_CLEAR);
		ctl.walk_step  = (state_q == ST_WALK);
		ctl.finish     = (state_q == ST_FINISH) && sts.out_free;
	end

endmodule

[rtl/pslfa_datapath.sv]
`timescale 1ns / 1ps

module pslfa_datapath import pslfa_pkg::*; #(
	parameter int SEG_BYTES    = DEF_SEG_BYTES,
	parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
	parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	output sts_t              sts,
	input  logic [LOG2_W-1:0] cfg_log2,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp
);

	// Address width: holds the segment end plus two slots, and at least 17 bits
	localparam int SEG_W = $clog2(SEG_BYTES) + 1;
	localparam int AW    = (SEG_W > OFF_W + 1) ? SEG_W : OFF_W + 1;
	localparam logic [AW-1:0] SEG_END = AW'(SEG_BYTES);
	localparam logic [AW-1:0] PMASK   = AW'(PAGE_BYTES - 1);
	localparam logic [AW-1:0] HDR     = AW'(HEADER_BYTES);

	logic [OFF_W-1:0]    mem [STORE_DEPTH];
	logic [OFF_W-1:0]    rd_data_q;

	logic [LOG2_W-1:0]   active_q;
	logic [STORE_AW-1:0] clr_idx_q;
	logic [AW-1:0]       walk_a_q;
	logic [AW-1:0]       cnt_q;
	logic [AW-1:0]       start_q;
	logic [OFF_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [OFF_W-1:0]    off_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [AW-1:0]       size_w, mask_w, start_c, alim, a_next, link;
	logic                walk_lt, island;
	logic [CNT_W-1:0]    count_init;
	logic [AW-1:0]       off_w;
	logic                out_rng, misal;

	rsp_t                rsp_d;
	logic [OFF_W-1:0]    head_d;
	logic [CNT_W-1:0]    count_d;
	logic                push;

	logic                wr_en;
	logic [STORE_AW-1:0] wr_addr;
	logic [OFF_W-1:0]    wr_data;

	// Slot geometry for the active size
	always_comb begin
		size_w  = AW'(1) << active_q;
		mask_w  = size_w - AW'(1);
		start_c = (HDR + mask_w) & ~mask_w;
		alim    = SEG_END - size_w;
		walk_lt = walk_a_q < alim;
		a_next  = walk_a_q + size_w;
		island  = 1'b0;
		if ((a_next & PMASK) == '0) begin
			link = a_next + size_w;
		end else if ((walk_a_q & PMASK) == '0) begin
			link   = '0;
			island = 1'b1;
		end else begin
			link = a_next;
		end
		count_init = (cnt_q > AW'(COUNT_MAX)) ? COUNT_MAX : cnt_q[CNT_W-1:0];
	end

	// Check a freed offset
	always_comb begin
		off_w   = AW'(off_q);
		out_rng = (off_w < start_q) || (off_w >= SEG_END);
		misal   = (off_q & mask_w[OFF_W-1:0]) != '0;
	end

	// Resolve the held request
	always_comb begin
		rsp_d   = '{alloc_offset: '0, status: STS_OK, free_slots: count_q};
		head_d  = head_q;
		count_d = count_q;
		push    = 1'b0;
		unique case (cmd_q)
			CMD_ALLOC: begin
				if (count_q == '0) begin
					rsp_d.status = STS_NOFREE;
				end else begin
					rsp_d.alloc_offset = head_q;
					head_d             = rd_data_q;
					count_d            = count_q - CNT_W'(1);
				end
			end
			CMD_FREE: begin
				if (out_rng) begin
					rsp_d.status = STS_RANGE;
				end else if (misal) begin
					rsp_d.status = STS_ALIGN;
				end else begin
					push    = 1'b1;
					head_d  = off_q;
					count_d = (count_q < COUNT_MAX) ? count_q + CNT_W'(1) : count_q;
				end
			end
			default: ;
		endcase
		rsp_d.free_slots = count_d;
	end

	// Select the link store write
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		priority if (ctl.clear_step) begin
			wr_en   = 1'b1;
			wr_addr = clr_idx_q;
		end else if (ctl.walk_step) begin
			wr_en = 1'b1;
			if (walk_lt) begin
				wr_addr = walk_a_q[OFF_W-1:2];
				wr_data = link[OFF_W-1:0];
			end else begin
				wr_addr = alim[OFF_W-1:2];
			end
		end else if (ctl.finish && push) begin
			wr_en   = 1'b1;
			wr_addr = off_q[OFF_W-1:2];
			wr_data = head_q;
		end
	end

	// Link store: one write port, one registered read port at the head
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (ctl.rd_en) rd_data_q <= mem[head_q[OFF_W-1:2]];
	end

	// Initialization walk and list state
	always_ff @(posedge clk) begin
		if (ctl.init_start) begin
			clr_idx_q <= '0;
			if (cfg_log2 < LOG2_MIN) begin
				active_q <= LOG2_MIN;
			end else if (cfg_log2 > LOG2_MAX) begin
				active_q <= LOG2_MAX;
			end else begin
				active_q <= cfg_log2;
			end
		end
		if (ctl.clear_step) begin
			clr_idx_q <= clr_idx_q + STORE_AW'(1);
			if (sts.clear_last) begin
				walk_a_q <= start_c;
				start_q  <= start_c;
				cnt_q    <= (SEG_END - start_c) >> active_q;
			end
		end
		if (ctl.walk_step && walk_lt) begin
			walk_a_q <= a_next;
			if (island && cnt_q != '0) cnt_q <= cnt_q - AW'(1);
		end
		if (ctl.walk_step && !walk_lt) begin
			head_q  <= start_q[OFF_W-1:0];
			count_q <= count_init;
		end else if (ctl.finish) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
		if (ctl.accept) begin
			cmd_q <= req.command;
			off_q <= req.slot_offset;
		end
		if (ctl.finish) rsp_q <= rsp_d;
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.clear_last = &clr_idx_q;
		sts.walk_done  = !walk_lt;
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/paged_slot_free_list_allocator.sv]
`timescale 1ns / 1ps
// Paged slot free-list allocator.
// Request channel (req_valid/req_stall/req): command allocate, free or
// reinitialize, with the slot offset used by free. Response channel
// (rsp_valid/rsp_stall/rsp): one response per request with the allocated
// offset, a status code and the free slot count after the request.
// Allocate and free pass through the FINISH state before the response is
// valid, and no new request is taken until that state is done: the head
// slot's link is read from the store at the accepting edge, and FINISH
// updates the list and loads the response once the output register is free.
// Reinitialize passes through a setup state, clears the 16384-entry
// link store, then walks the slots one per cycle, then responds.
// Reset runs the same clearing pass and walk with a slot size of 16
// bytes; no request is accepted until it completes.
// The response sits in an output register: while rsp_stall is high it holds
// its value, and the block may accept and work on one more request, then
// waits with req_stall high until the response register frees up.
// slot_size_log2 lives at APB address 0 and takes effect at reinitialize.

module paged_slot_free_list_allocator import pslfa_pkg::*; #(
	parameter int SEG_BYTES    = DEF_SEG_BYTES,
	parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
	parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [LOG2_W-1:0] slot_size_log2_q;
	ctl_t              ctl;
	sts_t              sts;

	// Configuration register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_size_log2_q <= LOG2_RST;
		end else if (psel && penable && pwrite && pready
				&& paddr[APB_AW-1] == REG_SLOT_SIZE_LOG2) begin
			slot_size_log2_q <= pwdata[LOG2_W-1:0];
		end
	end

	// Configuration read back
	always_comb begin
		pready = 1'b1;
		prdata = (paddr[APB_AW-1] == REG_SLOT_SIZE_LOG2) ? APB_DW'(slot_size_log2_q) : '0;
	end

	pslfa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_command (req.command),
		.req_stall   (req_stall),
		.sts         (sts),
		.ctl         (ctl)
	);

	pslfa_datapath #(
		.SEG_BYTES    (SEG_BYTES),
		.PAGE_BYTES   (PAGE_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cfg_log2  (slot_size_log2_q),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

[rtl/pslfa_checker.sv]
`timescale 1ns / 1ps

module pslfa_checker import pslfa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// One request at a time: the cycle after acceptance is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted back to back");

	// Count never passes its ceiling
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.free_slots <= COUNT_MAX)
		else $error("free count above maximum");

	// Empty means no offset and no free slots
	a_nofree: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STS_NOFREE |-> rsp.alloc_offset == '0
			&& rsp.free_slots == '0)
		else $error("empty status with offset or count");

	// A nonzero offset comes only from a successful allocate
	a_offset_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.alloc_offset != '0 |-> rsp.status == STS_OK)
		else $error("offset reported with error status");

endmodule

bind paged_slot_free_list_allocator pslfa_checker u_pslfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import pslfa_pkg::*;

	localparam int SEG   = DEF_SEG_BYTES;
	localparam int PAGE  = DEF_PAGE_BYTES;
	localparam int HDR   = DEF_HEADER_BYTES;
	localparam int LIMIT = 2_000_000;
	localparam int HOLD_AT  = 60;
	localparam int HOLD_LEN = 300;
	localparam int QUEUE_MAX = 4;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_stall;
	rsp_t              rsp;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	paged_slot_free_list_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Free list shadow: register, active size, head, count and links
	logic [LOG2_W-1:0] cfg_log2;
	int unsigned       act_log2;
	logic [OFF_W-1:0]  head_off;
	logic [CNT_W-1:0]  free_cnt;
	logic [OFF_W-1:0]  link_mem [STORE_DEPTH];

	req_t        pend_q[$];
	rsp_t        alloc_rsp_q[$];
	logic [OFF_W-1:0] held_slots[$];

	int  cycles = 0;
	int  mismatches = 0;
	int  rsp_taken = 0;
	bit  req_fired = 1'b0;
	bit  rsp_fired = 1'b0;
	bit  sending = 1'b0;
	int  send_gap = 0;
	int  send_quiet = 0;
	int  rsp_wait = 0;
	int  rcv_quiet = 0;
	int  hold_left = 0;
	int unsigned gen_log2;
	int  reinit_budget = 2;

	// Clock: 12 ns period
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int unsigned eff_log2(logic [LOG2_W-1:0] v);
		if (v < LOG2_MIN)
			return LOG2_MIN;
		if (v > LOG2_MAX)
			return LOG2_MAX;
		return v;
	endfunction

	function automatic int unsigned list_base(int unsigned lg);
		int unsigned sz;
		sz = 1 << lg;
		return (HDR + sz - 1) & ~(sz - 1);
	endfunction

	function automatic logic [STORE_AW-1:0] link_index(logic [OFF_W-1:0] off);
		return off[OFF_W-1:2];
	endfunction

	// Rebuild the list in address order, skipping the first slot of each page
	function automatic void rebuild_list();
		int unsigned sz, lim, a, first, cnt, link;
		act_log2 = eff_log2(cfg_log2);
		sz = 1 << act_log2;
		foreach (link_mem[i])
			link_mem[i] = '0;
		first = list_base(act_log2);
		cnt = (SEG > first) ? ((SEG - first) >> act_log2) : 0;
		lim = SEG - sz;
		for (a = first; a < lim; a += sz) begin
			if (((a + sz) & (PAGE - 1)) == 0) begin
				link = a + 2 * sz;
			end else if ((a & (PAGE - 1)) == 0) begin
				link = 0;
				if (cnt > 0)
					cnt--;
			end else begin
				link = a + sz;
			end
			link_mem[link_index(OFF_W'(a))] = OFF_W'(link);
		end
		link_mem[link_index(OFF_W'(lim))] = '0;
		head_off = OFF_W'(first);
		free_cnt = (cnt > COUNT_MAX) ? COUNT_MAX : CNT_W'(cnt);
	endfunction

	// Apply one request to the shadow list and return its response
	function automatic rsp_t list_apply(req_t r);
		rsp_t o;
		int unsigned sz, off;
		o = '0;
		o.status = STS_OK;
		sz = 1 << act_log2;
		off = r.slot_offset;
		case (r.command)
			CMD_ALLOC: begin
				if (free_cnt == 0) begin
					o.status = STS_NOFREE;
				end else begin
					o.alloc_offset = head_off;
					head_off = link_mem[link_index(head_off)];
					free_cnt--;
				end
			end
			CMD_FREE: begin
				if (off < list_base(act_log2) || off >= SEG) begin
					o.status = STS_RANGE;
				end else if ((off & (sz - 1)) != 0) begin
					o.status = STS_ALIGN;
				end else begin
					link_mem[link_index(r.slot_offset)] = head_off;
					head_off = r.slot_offset;
					if (free_cnt < COUNT_MAX)
						free_cnt++;
				end
			end
			CMD_REINIT: begin
				rebuild_list();
			end
			default: begin
			end
		endcase
		o.free_slots = free_cnt;
		return o;
	endfunction

	// Draw a random wait, with occasional runs of no waiting
	function automatic int draw_wait(ref int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	// Request driver: present the next pending request after its gap
	always @(negedge clk) begin
		if (req_fired) begin
			req_fired = 1'b0;
			sending = 1'b0;
			send_gap = draw_wait(send_quiet);
		end
		if (!sending && arst_n) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pend_q.size() > 0) begin
				req <= pend_q.pop_front();
				sending = 1'b1;
			end
		end
		req_valid <= sending;
	end

	// Response stall: random waits, plus one long hold-off
	always @(negedge clk) begin
		if (rsp_fired) begin
			rsp_fired = 1'b0;
			rsp_wait = draw_wait(rcv_quiet);
			if (rsp_taken == HOLD_AT)
				hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (rsp_wait > 0) begin
			rsp_wait--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Monitor: predict on each accepted request, check each accepted response
	always @(posedge clk) begin : mon
		rsp_t want;
		cycles++;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			if (req_valid && !req_stall) begin
				alloc_rsp_q.push_back(list_apply(req));
				req_fired = 1'b1;
			end
			if (rsp_valid && !rsp_stall) begin
				rsp_fired = 1'b1;
				rsp_taken++;
				if (alloc_rsp_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected response %h", $time, rsp);
				end else begin
					want = alloc_rsp_q.pop_front();
					if (rsp.alloc_offset !== want.alloc_offset) begin
						mismatches++;
						$display("%0t: alloc_offset expected %h actual %h",
							$time, want.alloc_offset, rsp.alloc_offset);
					end
					if (rsp.status !== want.status) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
					end
					if (rsp.free_slots !== want.free_slots) begin
						mismatches++;
						$display("%0t: free_slots expected %0d actual %0d",
							$time, want.free_slots, rsp.free_slots);
					end
					if (want.status == STS_OK && want.alloc_offset != 0)
						held_slots.push_back(want.alloc_offset);
				end
			end
		end
	end

	task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [OFF_W-1:0] off);
		req_t r;
		while (pend_q.size() >= QUEUE_MAX)
			@(negedge clk);
		r.command = cmd;
		r.slot_offset = off;
		pend_q.push_back(r);
	endtask

	// Hold until every request has been answered
	task automatic wait_idle();
		while (pend_q.size() != 0 || sending || alloc_rsp_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_slot_log2(input logic [LOG2_W-1:0] v);
		logic [APB_DW-1:0] data;
		data = $urandom();
		data[LOG2_W-1:0] = v;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(4 * REG_SLOT_SIZE_LOG2);
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		cfg_log2 = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Random requests: mostly allocations and well-formed frees
	task automatic random_requests(input int n, input int alloc_pct, input int good_pct);
		int unsigned sz, base, r, idx;
		logic [OFF_W-1:0] off;
		for (int i = 0; i < n; i++) begin
			sz = 1 << gen_log2;
			base = list_base(gen_log2);
			r = $urandom_range(0, 99);
			off = $urandom();
			if (reinit_budget > 0 && $urandom_range(0, 249) == 0) begin
				reinit_budget--;
				held_slots.delete();
				push_req(CMD_REINIT, off);
			end else if (r < alloc_pct) begin
				push_req(CMD_ALLOC, off);
			end else if (r < alloc_pct + good_pct) begin
				if (held_slots.size() > 0 && $urandom_range(0, 1)) begin
					idx = $urandom_range(0, held_slots.size() - 1);
					off = held_slots[idx];
					held_slots.delete(idx);
				end else begin
					off = OFF_W'(base + $urandom_range(0, (SEG - base) / sz - 1) * sz);
				end
				push_req(CMD_FREE, off);
			end else if (r < 92) begin
				push_req(CMD_FREE, off);
			end else if (r < 97) begin
				push_req(CMD_FREE, OFF_W'($urandom_range(0, base - 1)));
			end else begin
				push_req(CMD_UNUSED, off);
			end
		end
	endtask

	int unsigned ph_log2[6]  = '{11, 2, 0, 15, 9, 4};
	int          ph_items[6] = '{170, 180, 120, 150, 160, 120};
	int          ph_alloc[6] = '{60, 20, 40, 55, 50, 40};
	int          ph_good[6]  = '{25, 65, 45, 30, 35, 45};

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_log2 = LOG2_RST;
		rebuild_list();
		gen_log2 = act_log2;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: edges of the offset range, alignment, islands, double free
		push_req(CMD_ALLOC, 16'hFFFF);
		push_req(CMD_ALLOC, 16'h0000);
		push_req(CMD_FREE, 16'd64);
		push_req(CMD_FREE, 16'h0000);
		push_req(CMD_FREE, 16'd63);
		push_req(CMD_FREE, 16'hFFFF);
		push_req(CMD_FREE, 16'hFFF0);
		push_req(CMD_FREE, 16'hFFF8);
		push_req(CMD_FREE, 16'h1000);
		push_req(CMD_UNUSED, 16'hFFFF);
		push_req(CMD_ALLOC, 16'h5555);
		push_req(CMD_ALLOC, 16'hAAAA);
		push_req(CMD_ALLOC, 16'h0000);
		push_req(CMD_FREE, 16'h0008);
		push_req(CMD_REINIT, 16'hFFFF);
		push_req(CMD_ALLOC, 16'h0000);
		push_req(CMD_FREE, 16'd64);
		push_req(CMD_FREE, 16'd64);
		push_req(CMD_ALLOC, 16'h0000);
		push_req(CMD_UNUSED, 16'h0000);
		random_requests(180, 45, 40);

		// Step through slot sizes, extremes and out-of-range values included
		foreach (ph_log2[p]) begin
			wait_idle();
			write_slot_log2(LOG2_W'(ph_log2[p]));
			gen_log2 = eff_log2(LOG2_W'(ph_log2[p]));
			held_slots.delete();
			push_req(CMD_REINIT, OFF_W'($urandom()));
			random_requests(ph_items[p], ph_alloc[p], ph_good[p]);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
